@@ hw/rtl/rlc_dp_pkg.sv @@
// ----------------------------------------------------------------------------
// Run-length constrained striping: shared package
// Widths, cost encodings, register indexes and the saturating cost add used
// by the run-length constrained two-colour cost block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlc_dp_pkg;

    localparam int COST_W = 22;
    localparam int LEN_W  = 11;
    localparam int CFG_W  = 11;
    localparam int IDX_W  = 2;

    typedef logic [COST_W-1:0] cost_t;
    typedef logic [LEN_W-1:0]  len_t;

    // All ones marks an entry that no valid striping reaches.
    localparam cost_t COST_UNREACH = 22'h3F_FFFF;
    localparam cost_t COST_SAT     = 22'h1F_FFFF;

    // Pixels per column never exceed this, whatever is written to rows.
    localparam len_t ROWS_CAP = 11'd1024;

    localparam logic [IDX_W-1:0] CFG_ROWS    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MIN_RUN = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_RUN = 2'd2;

    // Adds a column cost to a stored cost, keeping unreachable entries so and
    // saturating reachable ones.
    function automatic cost_t cost_add(input cost_t a, input len_t c);
        cost_t s;
        begin
            s = a + {{(COST_W-LEN_W){1'b0}}, c};
            if (a == COST_UNREACH)
            begin
                cost_add = COST_UNREACH;
            end
            else if (s > COST_SAT)
            begin
                cost_add = COST_SAT;
            end
            else
            begin
                cost_add = s;
            end
        end
    endfunction

    function automatic cost_t cost_min(input cost_t a, input cost_t b);
        begin
            cost_min = (b < a) ? b : a;
        end
    endfunction

endpackage

@@ hw/rtl/rlc_dp_ram.sv @@
// ----------------------------------------------------------------------------
// Run-length constrained striping: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlc_dp_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/run_length_constrained_two_color_dp.sv @@
// ----------------------------------------------------------------------------
// Run-length constrained two-colour striping, least repaint cost
// Columns arrive one per transaction as a dark-pixel count. A column is taken
// at a rising edge with start high and busy low; busy then stays high until
// the column is folded into the cost memory. For each column the sweep reads
// one cost memory word (both colours) per cycle, shifts it up one run length
// with the column cost added, and writes it back. The first column of an
// image skips the sweep. On a column marked last, done pulses for one cycle
// with min_cost and feasible in the cycle busy falls; the receiver cannot
// stall and must take it then. Configuration (rows, min_run, max_run) is
// written through cfg_we/cfg_idx/cfg_data; the user must write it only while
// busy is low, which the block does not enforce, and it applies from the next
// column. Reset loads the register defaults and starts a new image; the
// memory needs no clearing pass since a fill count marks which run lengths
// hold valid costs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module run_length_constrained_two_color_dp #(
    parameter int MAX_RUN = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [10:0] dark_count,
    input  logic        last_column,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [10:0] cfg_data,
    output logic        done,
    output logic [20:0] min_cost,
    output logic        feasible
);

    localparam int ADDR_W  = $clog2(MAX_RUN);
    localparam int RUN_CAP = (MAX_RUN > 2047) ? 2047 : MAX_RUN;
    localparam rlc_dp_pkg::len_t RUN_CAP_W = rlc_dp_pkg::LEN_W'(RUN_CAP);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t               state_reg, state_next;
    rlc_dp_pkg::len_t     rows_reg, rows_next;
    rlc_dp_pkg::len_t     min_run_reg, min_run_next;
    rlc_dp_pkg::len_t     max_run_reg, max_run_next;
    rlc_dp_pkg::len_t     len_reg, len_next;
    logic                 at_start_reg, at_start_next;
    logic                 last_reg, last_next;
    rlc_dp_pkg::len_t     pay0_reg, pay0_next;
    rlc_dp_pkg::len_t     pay1_reg, pay1_next;
    rlc_dp_pkg::len_t     rd_l_reg, rd_l_next;
    logic                 dv_reg, dv_next;
    rlc_dp_pkg::len_t     dl_reg, dl_next;
    rlc_dp_pkg::cost_t    sw0_reg, sw0_next;
    rlc_dp_pkg::cost_t    sw1_reg, sw1_next;
    rlc_dp_pkg::cost_t    fin_reg, fin_next;
    logic                 done_reg, done_next;
    logic [20:0]          min_cost_reg, min_cost_next;
    logic                 feasible_reg, feasible_next;

    rlc_dp_pkg::len_t     mx;
    rlc_dp_pkg::len_t     r_eff;
    rlc_dp_pkg::len_t     dk_eff;
    rlc_dp_pkg::len_t     top;
    rlc_dp_pkg::cost_t    old0, old1, add0, add1, x0, x1, best;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [2*rlc_dp_pkg::COST_W-1:0] ram_wdata, ram_rdata;

    // Word l-1 holds the costs of run length l, colour 1 in the upper half.
    rlc_dp_ram #(
        .WIDTH (2*rlc_dp_pkg::COST_W),
        .DEPTH (MAX_RUN)
    ) u_cost_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mx     = (max_run_reg > RUN_CAP_W) ? RUN_CAP_W : max_run_reg;
    assign r_eff  = (rows_reg > rlc_dp_pkg::ROWS_CAP) ? rlc_dp_pkg::ROWS_CAP : rows_reg;
    assign dk_eff = (dark_count > r_eff) ? r_eff : dark_count;
    assign top    = (len_reg < mx) ? len_reg : mx;

    assign old0 = ram_rdata[rlc_dp_pkg::COST_W-1:0];
    assign old1 = ram_rdata[2*rlc_dp_pkg::COST_W-1:rlc_dp_pkg::COST_W];
    assign add0 = rlc_dp_pkg::cost_add(old0, pay0_reg);
    assign add1 = rlc_dp_pkg::cost_add(old1, pay1_reg);
    assign x0   = at_start_reg ? {{(rlc_dp_pkg::COST_W-rlc_dp_pkg::LEN_W){1'b0}}, pay0_reg}
                               : rlc_dp_pkg::cost_add(sw0_reg, pay0_reg);
    assign x1   = at_start_reg ? {{(rlc_dp_pkg::COST_W-rlc_dp_pkg::LEN_W){1'b0}}, pay1_reg}
                               : rlc_dp_pkg::cost_add(sw1_reg, pay1_reg);

    // The sweep runs downwards: word l is written (as run length l+1) once it
    // has come back through the registered read port, and the read in flight is
    // always below it, so read and write never meet on one word.
    always_comb
    begin
        ram_raddr = ADDR_W'(top - 11'd1);
        if (state_reg == ST_SWEEP)
        begin
            ram_raddr = ADDR_W'(rd_l_reg - 11'd1);
        end

        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(dl_reg);
        ram_wdata = {add1, add0};
        if (state_reg == ST_FINISH)
        begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {x1, x0};
        end
        else if (dv_reg && (dl_reg < mx))
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        min_run_next  = min_run_reg;
        max_run_next  = max_run_reg;
        len_next      = len_reg;
        at_start_next = at_start_reg;
        last_next     = last_reg;
        pay0_next     = pay0_reg;
        pay1_next     = pay1_reg;
        rd_l_next     = rd_l_reg;
        dv_next       = 1'b0;
        dl_next       = dl_reg;
        sw0_next      = sw0_reg;
        sw1_next      = sw1_reg;
        fin_next      = fin_reg;
        done_next     = 1'b0;
        min_cost_next = min_cost_reg;
        feasible_next = feasible_reg;
        best          = rlc_dp_pkg::COST_UNREACH;

        if (cfg_we)
        begin
            case (cfg_idx)
                rlc_dp_pkg::CFG_ROWS:    rows_next    = cfg_data;
                rlc_dp_pkg::CFG_MIN_RUN: min_run_next = cfg_data;
                rlc_dp_pkg::CFG_MAX_RUN: max_run_next = cfg_data;
                default: ;
            endcase
        end

        // Fold in one word read from the cost memory.
        if (dv_reg)
        begin
            if ((dl_reg >= min_run_reg) || (dl_reg == mx))
            begin
                sw0_next = rlc_dp_pkg::cost_min(sw0_reg, old1);
                sw1_next = rlc_dp_pkg::cost_min(sw1_reg, old0);
            end
            if ((dl_reg < mx) && (({1'b0, dl_reg} + 12'd1) >= {1'b0, min_run_reg}))
            begin
                fin_next = rlc_dp_pkg::cost_min(fin_reg, rlc_dp_pkg::cost_min(add0, add1));
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    last_next = last_column;
                    pay0_next = dk_eff;
                    pay1_next = r_eff - dk_eff;
                    sw0_next  = rlc_dp_pkg::COST_UNREACH;
                    sw1_next  = rlc_dp_pkg::COST_UNREACH;
                    fin_next  = rlc_dp_pkg::COST_UNREACH;
                    if (at_start_reg || (top == '0))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        dv_next    = 1'b1;
                        dl_next    = top;
                        rd_l_next  = top - 11'd1;
                        state_next = (top == 11'd1) ? ST_DRAIN : ST_SWEEP;
                    end
                end
            end
            ST_SWEEP:
            begin
                dv_next   = 1'b1;
                dl_next   = rd_l_reg;
                rd_l_next = rd_l_reg - 11'd1;
                if (rd_l_reg == 11'd1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                best = fin_reg;
                if ((mx != '0) && (min_run_reg <= 11'd1))
                begin
                    best = rlc_dp_pkg::cost_min(best, rlc_dp_pkg::cost_min(x0, x1));
                end
                done_next     = last_reg;
                feasible_next = (best != rlc_dp_pkg::COST_UNREACH);
                min_cost_next = (best == rlc_dp_pkg::COST_UNREACH) ? 21'd0 : best[20:0];
                if (last_reg)
                begin
                    len_next = '0;
                end
                else if (at_start_reg)
                begin
                    len_next = 11'd1;
                end
                else if (mx == '0)
                begin
                    len_next = '0;
                end
                else
                begin
                    len_next = (len_reg < mx) ? (len_reg + 11'd1) : mx;
                end
                at_start_next = last_reg;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rows_reg     <= 11'd1;
            min_run_reg  <= 11'd1;
            max_run_reg  <= 11'd1024;
            len_reg      <= '0;
            at_start_reg <= 1'b1;
            last_reg     <= 1'b0;
            pay0_reg     <= '0;
            pay1_reg     <= '0;
            rd_l_reg     <= '0;
            dv_reg       <= 1'b0;
            dl_reg       <= '0;
            sw0_reg      <= rlc_dp_pkg::COST_UNREACH;
            sw1_reg      <= rlc_dp_pkg::COST_UNREACH;
            fin_reg      <= rlc_dp_pkg::COST_UNREACH;
            done_reg     <= 1'b0;
            min_cost_reg <= '0;
            feasible_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rows_reg     <= rows_next;
            min_run_reg  <= min_run_next;
            max_run_reg  <= max_run_next;
            len_reg      <= len_next;
            at_start_reg <= at_start_next;
            last_reg     <= last_next;
            pay0_reg     <= pay0_next;
            pay1_reg     <= pay1_next;
            rd_l_reg     <= rd_l_next;
            dv_reg       <= dv_next;
            dl_reg       <= dl_next;
            sw0_reg      <= sw0_next;
            sw1_reg      <= sw1_next;
            fin_reg      <= fin_next;
            done_reg     <= done_next;
            min_cost_reg <= min_cost_next;
            feasible_reg <= feasible_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign min_cost = min_cost_reg;
    assign feasible = feasible_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a column is still in progress");

    a_infeasible_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !feasible) |-> (min_cost == 21'd0))
        else $error("infeasible result carries a non-zero cost");

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= RUN_CAP_W)
        else $error("fill count beyond the largest run length");

    a_sweep_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (rd_l_reg != '0))
        else $error("sweep issued a read below run length one");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == ST_SWEEP)) |-> (ram_waddr != ram_raddr))
        else $error("cost memory read and write meet on one word");
`endif

endmodule
